// ===== hw/rtl/salru_pkg.sv =====
// Shared types and constants for the set-associative LRU tag store.
// Used by salru_front, salru_back and the core; depends on nothing.
package salru_pkg;

  localparam int TAG_W   = 20;
  localparam int FIELD_W = 7;
  localparam int FIELD_LSB = 5;
  localparam int TAG_LSB   = 12;

  localparam logic [31:0] SET_MASK = 32'h0000_0FE0;
  localparam logic [31:0] TAG_MASK = 32'hFFFF_F000;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef enum logic [1:0] {
    BUS_NONE  = 2'd0,
    BUS_READ  = 2'd1,
    BUS_WRITE = 2'd2
  } bus_op_e;

  typedef struct packed {
    logic        kind;
    logic [31:0] address;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  set_index;
    logic [19:0] tag_value;
    logic [3:0]  entries_before;
    logic        is_read;
    logic        hit;
    logic [2:0]  hit_position;
    bus_op_e     bus_op;
    logic        writeback;
  } out_item_t;

  // Classified access as it waits between the front and back parts.
  typedef struct packed {
    logic               is_write;
    logic [FIELD_W-1:0] field;
    logic [TAG_W-1:0]   tag;
  } cls_t;

endpackage

// ===== hw/rtl/salru_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the per-set row store.
module salru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/salru_queue.sv =====
// Short FIFO that decouples the classifying front from the update back.
// Standalone; payload width set by parameter.
module salru_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] buf_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = buf_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/salru_front.sv =====
// Front part: accepts accesses, splits the address and reduces the set field.
// Depends on salru_pkg; feeds salru_queue.
module salru_front #(
  parameter int SETS = 128,
  localparam int SW = (SETS > 1) ? $clog2(SETS) : 1,
  localparam int QW = SW + $bits(salru_pkg::cls_t)
) (
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  salru_pkg::in_item_t  in_item_i,
  input  logic                 busy_i,
  input  logic                 full_i,
  output logic                 push_o,
  output logic [QW-1:0]        push_data_o
);

  import salru_pkg::*;

  cls_t               cls;
  logic [FIELD_W-1:0] rem;
  logic [SW-1:0]      set_idx;
  logic [31:0]        set_bits;
  logic [31:0]        tag_bits;

  assign in_stall_o = busy_i || full_i;
  assign push_o     = in_valid_i && !in_stall_o;

  assign set_bits = in_item_i.address & SET_MASK;
  assign tag_bits = in_item_i.address & TAG_MASK;

  always_comb begin
    cls.is_write = (in_item_i.kind == KIND_WRITE);
    cls.field    = set_bits[FIELD_LSB +: FIELD_W];
    cls.tag      = tag_bits[TAG_LSB +: TAG_W];
  end

  // Restoring reduction of the 7-bit field modulo SETS.
  always_comb begin
    rem = cls.field;
    for (int k = FIELD_W - 1; k >= 0; k--) begin
      if (((SETS << k) < (1 << FIELD_W)) && (int'(rem) >= (SETS << k))) begin
        rem = rem - FIELD_W'(SETS << k);
      end
    end
    set_idx = SW'(rem);
  end

  assign push_data_o = {set_idx, cls};

endmodule

// ===== hw/rtl/salru_back.sv =====
// Back part: row read, tag match, LRU reorder and write-back, result register.
// Depends on salru_pkg and salru_ram; pops from salru_queue.
module salru_back #(
  parameter int SETS = 128,
  parameter int WAYS = 8,
  localparam int SW = (SETS > 1) ? $clog2(SETS) : 1,
  localparam int QW = SW + $bits(salru_pkg::cls_t)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  logic [QW-1:0]        q_data_i,
  output logic                 q_pop_o,
  output logic                 busy_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output salru_pkg::out_item_t out_item_o
);

  import salru_pkg::*;

  localparam int CW = $clog2(WAYS + 1);
  localparam int PW = $clog2(WAYS);

  typedef enum logic [2:0] {
    B_CLEAR  = 3'b001,
    B_READ   = 3'b010,
    B_UPDATE = 3'b100
  } back_state_e;

  typedef struct packed {
    logic [SW-1:0] set;
    cls_t          cls;
  } job_t;

  typedef struct packed {
    logic [CW-1:0]                cnt;
    logic [WAYS-1:0][TAG_W-1:0]   tags;
  } row_t;

  back_state_e state_q, state_d;
  logic [SW-1:0] clr_q, clr_d;
  job_t          job_q;
  out_item_t     out_q, out_d;
  logic          out_valid_q, out_valid_d;

  logic                ram_we, ram_re;
  logic [SW-1:0]       ram_waddr;
  logic [$bits(row_t)-1:0] ram_wdata, ram_rdata;
  row_t                rd_row, wr_row;
  job_t                head;
  logic                out_free, hit, full;
  logic [PW-1:0]       pos;

  assign head     = job_t'(q_data_i);
  assign rd_row   = row_t'(ram_rdata);
  assign out_free = !out_valid_q || !out_stall_i;
  assign busy_o   = (state_q == B_CLEAR);
  assign full     = (rd_row.cnt == CW'(WAYS));

  // Most recent valid match wins.
  always_comb begin
    hit = 1'b0;
    pos = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if ((CW'(i) < rd_row.cnt) && (rd_row.tags[i] == job_q.cls.tag)) begin
        hit = 1'b1;
        pos = PW'(i);
      end
    end
  end

  // Hit way or new tag to the front; ways ahead of a hit, all on a miss, shift down.
  always_comb begin
    wr_row.tags[0] = hit ? rd_row.tags[pos] : job_q.cls.tag;
    for (int i = 1; i < WAYS; i++) begin
      if (!hit || (PW'(i) <= pos)) begin
        wr_row.tags[i] = rd_row.tags[i-1];
      end else begin
        wr_row.tags[i] = rd_row.tags[i];
      end
    end
    wr_row.cnt = (!hit && !full) ? CW'(rd_row.cnt + 1'b1) : rd_row.cnt;
  end

  always_comb begin
    out_d.set_index      = job_q.cls.field;
    out_d.tag_value      = job_q.cls.tag;
    out_d.entries_before = 4'(rd_row.cnt);
    out_d.is_read        = !job_q.cls.is_write;
    out_d.hit            = hit;
    out_d.hit_position   = hit ? 3'(pos) : 3'd0;
    if (hit) begin
      out_d.bus_op = BUS_NONE;
    end else if (job_q.cls.is_write) begin
      out_d.bus_op = BUS_WRITE;
    end else begin
      out_d.bus_op = BUS_READ;
    end
    out_d.writeback      = !hit && job_q.cls.is_write && full;
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && out_stall_i;
    q_pop_o     = 1'b0;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = job_q.set;
    ram_wdata   = wr_row;
    case (state_q)
      B_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == SW'(SETS - 1)) begin
          state_d = B_READ;
        end
      end
      B_READ: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          ram_re  = 1'b1;
          state_d = B_UPDATE;
        end
      end
      B_UPDATE: begin
        // Hold the read row until the result register frees up.
        if (out_free) begin
          ram_we      = 1'b1;
          out_valid_d = 1'b1;
          state_d     = B_READ;
        end
      end
      default: begin
        state_d = B_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      job_q <= head;
    end
    if ((state_q == B_UPDATE) && out_free) begin
      out_q <= out_d;
    end
  end

  salru_ram #(
    .WIDTH ($bits(row_t)),
    .DEPTH (SETS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (head.set),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== hw/rtl/set_assoc_lru_tag_store_core.sv =====
// Set-associative tag store with true LRU order per set.
// Accesses enter on the in channel as {kind, address}; every access yields one
// beat on the out channel with set, tag, prior fill count, hit, hit position,
// bus request and write-back flag. Both channels use valid/stall: a beat moves
// on a rising edge with valid high and stall low.
// Each set is one row of a row RAM holding the fill count and the tags in
// recency order. The back part reads the row in its read state, then in its
// update state writes the reordered row and loads the result register; it
// takes a new access only after that update. An access on an idle block
// passes the queue, the job and row registers and then the result register.
// A two-entry queue sits between front and back, so inputs keep arriving while
// the result register is held by a stalling receiver; once the queue is full,
// in_stall_o rises. The back holds a read row until the result register frees.
// After reset a clearing pass writes every row to empty, one per cycle;
// in_stall_o stays high during that pass.
// Depends on salru_pkg, salru_front, salru_queue, salru_back, salru_ram.
module set_assoc_lru_tag_store_core #(
  parameter int SETS = 128,
  parameter int WAYS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  salru_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output salru_pkg::out_item_t out_item_o
);

  import salru_pkg::*;

  localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int QW = SW + $bits(cls_t);

  logic          busy, push, full, pop, q_valid;
  logic [QW-1:0] push_data, q_data;

  salru_front #(
    .SETS (SETS)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .busy_i      (busy),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  salru_queue #(
    .WIDTH (QW),
    .DEPTH (2)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  salru_back #(
    .SETS (SETS),
    .WAYS (WAYS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (pop),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  a_no_accept_while_clearing: assert property (
    @(posedge clk_i) disable iff (!rst_ni) busy |-> in_stall_o
  ) else $error("input taken during clearing pass");

  a_hit_means_no_bus: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.hit == (out_item_o.bus_op == BUS_NONE))
  ) else $error("hit and bus request disagree");

  a_writeback_on_full_write_miss: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.writeback) |->
      ((out_item_o.bus_op == BUS_WRITE) && (out_item_o.entries_before == 4'(WAYS)))
  ) else $error("write-back without a full-set write miss");

  a_queue_pop_needs_data: assert property (
    @(posedge clk_i) disable iff (!rst_ni) pop |-> q_valid
  ) else $error("pop from empty queue");

endmodule
